>>> sv/odd_even_partition_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the odd/even partition block
// Shared property shapes, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ODD_EVEN_PARTITION_TOP_MACROS_SVH
`define ODD_EVEN_PARTITION_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define OEP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("odd_even_partition: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define OEP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("odd_even_partition: assertion failed");

`endif

>>> sv/oep_pkg.sv
// ----------------------------------------------------------------------------
// oep_pkg
// Sizes and shared types of the odd/even partition block.
// ----------------------------------------------------------------------------
`default_nettype none

package oep_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int ODD_POS = 0;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

endpackage

`default_nettype wire

>>> sv/oep_ram.sv
// ----------------------------------------------------------------------------
// oep_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module oep_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  wire logic [WIDTH-1:0]               wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic      [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/oep_seq.sv
// ----------------------------------------------------------------------------
// oep_seq
// Sequencer that loads the buffer, runs the two-pointer partition on it
// through the RAM and streams the result out of an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module oep_seq
   import oep_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic signed [DATA_W-1:0] req_tdata,
   input  wire logic                     req_tlast,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic signed [DATA_W-1:0]      rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser,
   output mem_req_type                   mem_req,
   input  wire logic [DATA_W-1:0]        mem_rd_data
);

   typedef enum logic [3:0] {
      S_LOAD,
      S_FRONT_RD,
      S_FRONT_CHK,
      S_BACK_RD,
      S_BACK_CHK,
      S_SWAP,
      S_EMIT_RD,
      S_EMIT_WT,
      S_EMIT_HOLD
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  emit_ff, emit_in;
   logic [DATA_W-1:0] fval_ff, fval_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              full;
   logic [CNT_W-1:0]  count_next;
   logic [IDX_W-1:0]  last_idx;

   assign full     = (count_ff == FULL_COUNT);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      emit_in       = emit_ff;
      fval_in       = fval_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      count_next    = count_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = lo_ff;
      mem_req.wdata = req_tdata;
      mem_req.raddr = lo_ff;

      case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = IDX_W'(count_ff);
                  count_next    = count_ff + CNT_W'(1);
               end
               count_in = count_next;
               if (req_tlast) begin
                  lo_in    = '0;
                  hi_in    = IDX_W'(count_next - CNT_W'(1));
                  emit_in  = '0;
                  state_in = S_FRONT_RD;
               end
            end
         end
         S_FRONT_RD: begin
            mem_req.raddr = lo_ff;
            state_in      = (lo_ff < hi_ff) ? S_FRONT_CHK : S_EMIT_RD;
         end
         S_FRONT_CHK: begin
            if (mem_rd_data[ODD_POS]) begin
               lo_in    = lo_ff + IDX_W'(1);
               state_in = S_FRONT_RD;
            end else begin
               fval_in  = mem_rd_data;
               state_in = S_BACK_RD;
            end
         end
         S_BACK_RD: begin
            mem_req.raddr = hi_ff;
            state_in      = (lo_ff < hi_ff) ? S_BACK_CHK : S_EMIT_RD;
         end
         S_BACK_CHK: begin
            if (!mem_rd_data[ODD_POS]) begin
               hi_in    = hi_ff - IDX_W'(1);
               state_in = S_BACK_RD;
            end else begin
               mem_req.we    = 1'b1;
               mem_req.waddr = lo_ff;
               mem_req.wdata = mem_rd_data;
               state_in      = S_SWAP;
            end
         end
         S_SWAP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hi_ff;
            mem_req.wdata = fval_ff;
            state_in      = S_FRONT_RD;
         end
         S_EMIT_RD: begin
            mem_req.raddr = emit_ff;
            state_in      = S_EMIT_WT;
         end
         S_EMIT_WT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = mem_rd_data;
            rsp_last_in  = (emit_ff == last_idx);
            rsp_ovf_in   = dropped_ff;
            state_in     = S_EMIT_HOLD;
         end
         S_EMIT_HOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_LOAD;
               end else begin
                  emit_in  = emit_ff + IDX_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fval_ff     <= fval_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

`default_nettype wire

>>> sv/odd_even_partition_top.sv
// ----------------------------------------------------------------------------
// odd_even_partition_top
// Buffers a run of signed words and returns them with odd values first.
// ----------------------------------------------------------------------------
// Usage: words arrive on the req channel, one element each; req_tlast marks
// the final element of an array. Up to DEPTH elements are held in a RAM;
// further ones are dropped and every result of that array then carries
// rsp_tuser set. After the last word the block partitions the RAM in place
// with a front and a back pointer and then returns all held elements on the
// rsp channel, the final one with rsp_tlast set.
// Throughput: loading takes one word per cycle. Each pointer step is a RAM
// read followed by a parity test; each swap adds the two stopping tests and
// a second write. Each result is a RAM read, an output register load and a
// handshake; the next result is read only after the previous one is taken.
// req_tready is high only while loading. A stalled rsp word holds in the
// output register until taken. Reset empties the buffer and returns the
// block to loading; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_even_partition_top
   import oep_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic signed [DATA_W-1:0] req_tdata,   // [31:0] value
   input  wire logic                     req_tlast,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic signed [DATA_W-1:0]      rsp_tdata,   // [31:0] value_res
   output logic                          rsp_tlast,
   output logic                          rsp_tuser    // [0] overflow
);

   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rd_data;

   oep_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   oep_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.we),
      .wr_addr (mem_req.waddr),
      .wr_data (mem_req.wdata),
      .rd_addr (mem_req.raddr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

>>> sv/oep_checker.sv
// ----------------------------------------------------------------------------
// oep_checker
// Port-level checks of the odd/even partition block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "odd_even_partition_top_macros.svh"

module oep_checker
   import oep_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic                     req_tlast,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic signed [DATA_W-1:0] rsp_tdata,
   input wire logic                     rsp_tlast,
   input wire logic                     rsp_tuser
);

   logic [DATA_W+1:0] rsp_word;
   logic              rsp_stall;
   logic              req_last_take;
   logic              rsp_last_take;

   assign rsp_word      = {rsp_tdata, rsp_tlast, rsp_tuser};
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign req_last_take = req_tvalid && req_tready && req_tlast;
   assign rsp_last_take = rsp_tvalid && rsp_tready && rsp_tlast;

   // A stalled result word stays valid and unchanged.
   `OEP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // No new word is taken while a result is pending.
   `OEP_ASSERT_SAME(a_no_load_while_emit, rsp_tvalid, !req_tready)

   // The word that closes an array stops loading until the array is returned.
   `OEP_ASSERT_NEXT(a_last_stops_load, req_last_take, !req_tready && !rsp_tvalid)

   // Once the final result is taken, loading resumes.
   `OEP_ASSERT_NEXT(a_resume_load, rsp_last_take, req_tready && !rsp_tvalid)

endmodule

bind odd_even_partition_top oep_checker u_oep_checker (.*);

`default_nettype wire

>>> dv/tb_odd_even_partition_top.sv
// ----------------------------------------------------------------------------
// tb_odd_even_partition_top
// Self-checking bench for the odd/even partition block. Arrays of words are
// queued by a stimulus process, sent by a clocked driver with random gaps and
// predicted on acceptance by an in-bench partition model. A clocked monitor
// applies random back-pressure and compares every result word, field by
// field, against the oldest predicted one. A short directed set covers the
// value extremes and small parity patterns; a random set follows with mostly
// short arrays, a full array and arrays that overflow the buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_odd_even_partition_top;
   import oep_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              last;
      logic              hold;
   } word_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              last;
      logic              overflow;
   } part_result_type;

   typedef enum int {
      PARITY_MIXED,
      PARITY_ALL_ODD,
      PARITY_ALL_EVEN,
      PARITY_ALTERNATE
   } parity_mode_type;

   localparam int RANDOM_WORDS = 205;
   localparam int QUIET_TAIL   = 30;
   localparam int DRAIN_CYCLES = 300;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic signed [DATA_W-1:0] req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic signed [DATA_W-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tuser;

   word_item_type   pending_words[$];
   part_result_type expected_results[$];

   logic [DATA_W-1:0] held_values[DEPTH];
   int                held_count = 0;
   bit                held_dropped = 1'b0;

   int   errors = 0;
   int   words_queued = 0;
   int   arrays_done = 0;
   int   overflow_arrays = 0;
   int   results_seen = 0;
   int   send_gap = 0;
   int   recv_stall = 0;
   int   calm_left = 0;
   logic quiet = 1'b0;

   odd_even_partition_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic add_word(input logic [DATA_W-1:0] value, input logic last,
                           input logic hold);
      word_item_type item;
      item.value = value;
      item.last  = last;
      item.hold  = hold;
      pending_words.push_back(item);
      words_queued++;
   endtask

   task automatic add_array(input int n, input parity_mode_type mode, input logic hold);
      logic [DATA_W-1:0] v;
      for (int i = 0; i < n; i++) begin
         v = $urandom();
         case (mode)
            PARITY_ALL_ODD:   v[ODD_POS] = 1'b1;
            PARITY_ALL_EVEN:  v[ODD_POS] = 1'b0;
            PARITY_ALTERNATE: v[ODD_POS] = i[0];
            default: ;
         endcase
         add_word(v, i == n - 1, hold && i == 0);
      end
   endtask

   task automatic partition_held(input int n);
      int lo;
      int hi;
      logic [DATA_W-1:0] t;
      lo = 0;
      hi = n - 1;
      while (lo < hi) begin
         while (lo < hi && held_values[lo][ODD_POS]) lo++;
         while (lo < hi && !held_values[hi][ODD_POS]) hi--;
         if (lo < hi) begin
            t = held_values[lo];
            held_values[lo] = held_values[hi];
            held_values[hi] = t;
         end
      end
   endtask

   task automatic absorb_word(input word_item_type item);
      part_result_type r;
      if (held_count < DEPTH) begin
         held_values[held_count] = item.value;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (item.last) begin
         partition_held(held_count);
         for (int k = 0; k < held_count; k++) begin
            r.value    = held_values[k];
            r.last     = (k == held_count - 1);
            r.overflow = held_dropped;
            expected_results.push_back(r);
         end
         arrays_done++;
         if (held_dropped) overflow_arrays++;
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         calm_left <= 0;
      end else if (calm_left != 0) begin
         calm_left <= calm_left - 1;
      end else if ($urandom_range(0, 99) == 0) begin
         calm_left <= $urandom_range(40, 150);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         quiet      <= 1'b0;
         send_gap    = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_word(pending_words.pop_front());
            if (!quiet && calm_left == 0 && $urandom_range(0, 3) == 0)
               send_gap = $urandom_range(1, 14);
         end
         quiet <= (pending_words.size() <= QUIET_TAIL);
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].hold && expected_results.size() != 0)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_words[0].value;
               req_tlast  <= pending_words[0].last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      part_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               flag_error($sformatf("unexpected result word value=%h", rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.value)
                  flag_error($sformatf("value %h, expected %h", rsp_tdata, want.value));
               if (rsp_tlast !== want.last)
                  flag_error($sformatf("last %b, expected %b", rsp_tlast, want.last));
               if (rsp_tuser !== want.overflow)
                  flag_error($sformatf("overflow %b, expected %b", rsp_tuser,
                                       want.overflow));
            end
         end
         if (recv_stall != 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (!quiet && calm_left == 0 && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(0, 13);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int n;
      int arr_idx;
      int directed_words;

      add_word(32'h8000_0000, 1'b1, 1'b0);
      add_word(32'h7FFF_FFFF, 1'b1, 1'b0);
      add_word(32'h0000_0000, 1'b0, 1'b0);
      add_word(32'hFFFF_FFFF, 1'b1, 1'b0);
      add_word(32'h0000_0001, 1'b0, 1'b0);
      add_word(32'h0000_0002, 1'b1, 1'b0);
      add_word(32'h0000_0002, 1'b0, 1'b0);
      add_word(32'h0000_0004, 1'b0, 1'b0);
      add_word(32'hFFFF_FFFA, 1'b1, 1'b0);
      add_word(32'h0000_0003, 1'b0, 1'b0);
      add_word(32'h0000_0005, 1'b0, 1'b0);
      add_word(32'h8000_0001, 1'b0, 1'b0);
      add_word(32'hFFFF_FFFF, 1'b1, 1'b0);
      add_word(32'hFFFF_FFFE, 1'b0, 1'b0);
      add_word(32'h0000_0001, 1'b0, 1'b0);
      add_word(32'hFFFF_FFFD, 1'b1, 1'b0);
      add_word(32'h8000_0000, 1'b0, 1'b0);
      add_word(32'h7FFF_FFFF, 1'b0, 1'b0);
      add_word(32'h0000_0000, 1'b0, 1'b0);
      add_word(32'hFFFF_FFFF, 1'b0, 1'b0);
      add_word(32'h5555_5555, 1'b0, 1'b0);
      add_word(32'hAAAA_AAAA, 1'b1, 1'b0);
      directed_words = words_queued;

      arr_idx = 0;
      while (words_queued < directed_words + RANDOM_WORDS) begin
         if (arr_idx == 3)
            n = DEPTH;
         else if (arr_idx == 7 || $urandom_range(0, 39) == 0)
            n = $urandom_range(DEPTH + 1, DEPTH + 8);
         else
            n = $urandom_range(1, 12);
         add_array(n, parity_mode_type'($urandom_range(0, 3)),
                   arr_idx == 0 || $urandom_range(0, 5) == 0);
         arr_idx++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0)
         flag_error($sformatf("%0d result words never arrived", expected_results.size()));
      $display("Sent %0d words in %0d arrays, %0d of which overflowed the buffer.",
               words_queued, arrays_done, overflow_arrays);
      $display("Checked %0d result words against the partition model.", results_seen);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d words unsent and %0d results outstanding.",
               pending_words.size(), expected_results.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/oep_pkg.sv
sv/oep_ram.sv
sv/oep_seq.sv
sv/odd_even_partition_top.sv
sv/oep_checker.sv
dv/tb_odd_even_partition_top.sv
